[hdl/ccpg_pkg.sv]
// shared constants, types and weight table for the cubic curve point generator
`timescale 1ns / 1ps

package ccpg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int WEIGHT_BITS  = 9;
  localparam int ACC_BITS     = COORD_BITS + WEIGHT_BITS;
  localparam int QUOT_BITS    = ACC_BITS - 7;
  localparam int DIV_SHIFT    = QUOT_BITS + 1;
  localparam int DIV_MUL      = ((2 ** DIV_SHIFT) + 2) / 3;
  localparam int PROD_BITS    = 2 * QUOT_BITS + 1;
  localparam int SAMPLE_BITS  = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [3:0][COORD_BITS-1:0]   coord_quad_t;
  typedef logic [WEIGHT_BITS-1:0]       weight_t;
  typedef logic [3:0][WEIGHT_BITS-1:0]  weight_row_t;
  typedef logic [SAMPLE_BITS-1:0]       sample_t;

  typedef enum logic {
    MODE_BEZIER  = 1'b0,
    MODE_BSPLINE = 1'b1
  } curve_mode_t;

  localparam sample_t LAST_SAMPLE = sample_t'(4);

  localparam logic REG_CURVE_MODE = 1'b0;

  // weight row for one sample, all rows sum to 384, element 0 weights p0
  function automatic weight_row_t weight_row(input curve_mode_t mode, input sample_t k);
    weight_row_t w;
    w = '0;
    unique case ({mode, k})
      {MODE_BEZIER,  3'd0}: w = {9'd0,   9'd0,   9'd0,   9'd384};
      {MODE_BEZIER,  3'd1}: w = {9'd6,   9'd54,  9'd162, 9'd162};
      {MODE_BEZIER,  3'd2}: w = {9'd48,  9'd144, 9'd144, 9'd48};
      {MODE_BEZIER,  3'd3}: w = {9'd162, 9'd162, 9'd54,  9'd6};
      {MODE_BEZIER,  3'd4}: w = {9'd384, 9'd0,   9'd0,   9'd0};
      {MODE_BSPLINE, 3'd0}: w = {9'd0,   9'd64,  9'd256, 9'd64};
      {MODE_BSPLINE, 3'd1}: w = {9'd1,   9'd121, 9'd235, 9'd27};
      {MODE_BSPLINE, 3'd2}: w = {9'd8,   9'd184, 9'd184, 9'd8};
      {MODE_BSPLINE, 3'd3}: w = {9'd27,  9'd235, 9'd121, 9'd1};
      {MODE_BSPLINE, 3'd4}: w = {9'd64,  9'd256, 9'd64,  9'd0};
      default:              w = '0;
    endcase
    return w;
  endfunction

endpackage

[hdl/ccpg_regs.sv]
// configuration register file with apb-style access
`timescale 1ns / 1ps

module ccpg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ccpg_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [ccpg_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [ccpg_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                               cfg_pready,
  output ccpg_pkg::curve_mode_t              curve_mode
);
  import ccpg_pkg::*;

  curve_mode_t mode_r;
  curve_mode_t mode_nxt;
  logic        wr_en;
  logic        reg_idx;

  assign reg_idx = cfg_paddr[CFG_ADDR_BITS-1];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (reg_idx == REG_CURVE_MODE)) begin
      mode_nxt = curve_mode_t'(cfg_pwdata[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BEZIER;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_CURVE_MODE) begin
      cfg_prdata = {{(CFG_DATA_BITS-1){1'b0}}, mode_r};
    end
  end

  assign cfg_pready = 1'b1;
  assign curve_mode = mode_r;

endmodule

[hdl/ccpg_blend.sv]
// weighted sum of four coordinates, then floored division by 384, two register stages
`timescale 1ns / 1ps

module ccpg_blend (
  input  logic                  clk,
  input  logic                  adv,
  input  ccpg_pkg::weight_row_t weights,
  input  ccpg_pkg::coord_quad_t coords,
  output ccpg_pkg::coord_t      point
);
  import ccpg_pkg::*;

  logic [ACC_BITS-1:0]  acc_r;
  logic [ACC_BITS-1:0]  acc_nxt;
  logic [QUOT_BITS-1:0] quot;
  logic [PROD_BITS-1:0] prod;
  coord_t               point_r;
  coord_t               point_nxt;

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      acc_nxt = acc_nxt + ACC_BITS'(weights[i]) * ACC_BITS'(coords[i]);
    end
  end

  // divide by 128 with a shift, then by 3 with a reciprocal multiply
  assign quot = acc_r[ACC_BITS-1:7];
  assign prod = PROD_BITS'(quot) * PROD_BITS'(DIV_MUL);
  assign point_nxt = COORD_BITS'(prod >> DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r   <= acc_nxt;
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule

[hdl/cubic_curve_point_generator_unit.sv]
// top level: segment register, sample sequencer and blend pipeline
`timescale 1ns / 1ps
// Cubic curve point generator.
// Input channel (in_*): one transfer carries four control points p0..p3.
// Output channel (out_*): five transfers per segment, sample_index 0..4 for
// t = 0, 1/4, 1/2, 3/4, 1; last_point marks the fifth.
// curve_mode (apb register 0): 0 cubic bezier, 1 uniform cubic b-spline.
// Each coordinate is the weighted sum of the four control coordinates,
// divided by 384 and floored.
// The first point of a segment passes the segment register, the
// accumulator register and the point register; then one point per cycle
// leaves while out_stall is low, so a segment holds the output for its five
// points; the next segment is taken in the cycle the sequencer issues the
// fifth sample of its predecessor into the blend pipeline.
// Reset clears all valid state and sets curve_mode to bezier.
// While a point waits under out_stall the whole pipeline holds and in_stall
// stays high; otherwise in_stall is high while the segment register is busy short of its last sample.
module cubic_curve_point_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ccpg_pkg::coord_t                   in_p0_x,
  input  ccpg_pkg::coord_t                   in_p0_y,
  input  ccpg_pkg::coord_t                   in_p1_x,
  input  ccpg_pkg::coord_t                   in_p1_y,
  input  ccpg_pkg::coord_t                   in_p2_x,
  input  ccpg_pkg::coord_t                   in_p2_y,
  input  ccpg_pkg::coord_t                   in_p3_x,
  input  ccpg_pkg::coord_t                   in_p3_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ccpg_pkg::coord_t                   out_point_x,
  output ccpg_pkg::coord_t                   out_point_y,
  output ccpg_pkg::sample_t                  out_sample_index,
  output logic                               out_last_point,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ccpg_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [ccpg_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [ccpg_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                               cfg_pready
);
  import ccpg_pkg::*;

  curve_mode_t curve_mode;
  logic        adv;
  logic        in_xfer;

  logic        seg_vld_r, seg_vld_nxt;
  sample_t     seg_k_r, seg_k_nxt;
  coord_quad_t xs_r, ys_r;

  logic        acc_vld_r;
  sample_t     acc_k_r;

  logic        out_vld_r;
  sample_t     out_k_r;
  weight_row_t weights;

  ccpg_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .curve_mode (curve_mode)
  );

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !(adv && (!seg_vld_r || (seg_k_r == LAST_SAMPLE)));
  assign in_xfer  = in_valid && !in_stall;

  // sample sequencer
  always_comb begin
    seg_vld_nxt = seg_vld_r;
    seg_k_nxt   = seg_k_r;
    if (in_xfer) begin
      seg_vld_nxt = 1'b1;
      seg_k_nxt   = '0;
    end else if (adv && seg_vld_r) begin
      if (seg_k_r == LAST_SAMPLE) begin
        seg_vld_nxt = 1'b0;
      end else begin
        seg_k_nxt = seg_k_r + sample_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_vld_r <= 1'b0;
      seg_k_r   <= '0;
      acc_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      seg_vld_r <= seg_vld_nxt;
      seg_k_r   <= seg_k_nxt;
      if (adv) begin
        acc_vld_r <= seg_vld_r;
        out_vld_r <= acc_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      xs_r <= {in_p3_x, in_p2_x, in_p1_x, in_p0_x};
      ys_r <= {in_p3_y, in_p2_y, in_p1_y, in_p0_y};
    end
    if (adv) begin
      acc_k_r <= seg_k_r;
      out_k_r <= acc_k_r;
    end
  end

  assign weights = weight_row(curve_mode, seg_k_r);

  ccpg_blend u_blend_x (
    .clk    (clk),
    .adv    (adv),
    .weights(weights),
    .coords (xs_r),
    .point  (out_point_x)
  );

  ccpg_blend u_blend_y (
    .clk    (clk),
    .adv    (adv),
    .weights(weights),
    .coords (ys_r),
    .point  (out_point_y)
  );

  assign out_valid        = out_vld_r;
  assign out_sample_index = out_k_r;
  assign out_last_point   = (out_k_r == LAST_SAMPLE);

`ifndef ASSERT_OFF
  a_seg_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_vld_r |-> (seg_k_r <= LAST_SAMPLE))
    else $error("segment sample index out of range");

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!seg_vld_r || (seg_k_r == LAST_SAMPLE)))
    else $error("input transfer while segment still busy");

  a_points_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_point) |=>
      (out_valid && (out_sample_index == $past(out_sample_index) + sample_t'(1))))
    else $error("gap or skip within a segment's points");

  a_segment_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_point) |=>
      (!out_valid || (out_sample_index == '0)))
    else $error("segment did not start at sample zero");
`endif

endmodule

[test/ccpg_point_checker.sv]
// point checker: tracks curve_mode, predicts the five curve points per segment and compares them
`timescale 1ns / 1ps

module ccpg_point_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  ccpg_pkg::coord_t                   in_p0_x,
  input  ccpg_pkg::coord_t                   in_p0_y,
  input  ccpg_pkg::coord_t                   in_p1_x,
  input  ccpg_pkg::coord_t                   in_p1_y,
  input  ccpg_pkg::coord_t                   in_p2_x,
  input  ccpg_pkg::coord_t                   in_p2_y,
  input  ccpg_pkg::coord_t                   in_p3_x,
  input  ccpg_pkg::coord_t                   in_p3_y,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  ccpg_pkg::coord_t                   out_point_x,
  input  ccpg_pkg::coord_t                   out_point_y,
  input  ccpg_pkg::sample_t                  out_sample_index,
  input  logic                               out_last_point,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ccpg_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [ccpg_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  input  logic                               cfg_pready,
  output int unsigned                        mismatch_count,
  output int unsigned                        points_pending,
  output int unsigned                        points_checked
);
  import ccpg_pkg::*;

  localparam int          POINTS_PER_SEGMENT = 5;
  localparam int unsigned BLEND_DIVISOR      = 384;
  localparam int          REPORT_LIMIT       = 10;
  localparam logic [CFG_ADDR_BITS-1:0] MODE_ADDR = {REG_CURVE_MODE, 2'b00};

  typedef logic [0:3][COORD_BITS-1:0] ctrl_coords_t;
  typedef logic [0:3][8:0]            blend_row_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    sample_t index;
    logic    last;
  } curve_point_t;

  curve_point_t expected_points[$];
  curve_mode_t  active_mode;
  curve_point_t want;
  curve_point_t got;

  // weights over 384, element j weights control point j
  function automatic blend_row_t blend_row(curve_mode_t m, int k);
    blend_row_t r;
    r = '0;
    if (m == MODE_BEZIER) begin
      case (k)
        0: r = {9'd384, 9'd0,   9'd0,   9'd0};
        1: r = {9'd162, 9'd162, 9'd54,  9'd6};
        2: r = {9'd48,  9'd144, 9'd144, 9'd48};
        3: r = {9'd6,   9'd54,  9'd162, 9'd162};
        4: r = {9'd0,   9'd0,   9'd0,   9'd384};
        default: r = '0;
      endcase
    end else begin
      case (k)
        0: r = {9'd64,  9'd256, 9'd64,  9'd0};
        1: r = {9'd27,  9'd235, 9'd121, 9'd1};
        2: r = {9'd8,   9'd184, 9'd184, 9'd8};
        3: r = {9'd1,   9'd121, 9'd235, 9'd27};
        4: r = {9'd0,   9'd64,  9'd256, 9'd64};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic coord_t blend(blend_row_t r, ctrl_coords_t c);
    int unsigned acc;
    acc = 0;
    for (int j = 0; j < 4; j++) begin
      acc = acc + 32'(r[j]) * 32'(c[j]);
    end
    return coord_t'(acc / BLEND_DIVISOR);
  endfunction

  function automatic void queue_curve_points(curve_mode_t m, ctrl_coords_t xs, ctrl_coords_t ys);
    curve_point_t p;
    for (int k = 0; k < POINTS_PER_SEGMENT; k++) begin
      p.x     = blend(blend_row(m, k), xs);
      p.y     = blend(blend_row(m, k), ys);
      p.index = sample_t'(k);
      p.last  = (k == POINTS_PER_SEGMENT - 1);
      expected_points.push_back(p);
    end
  endfunction

  function automatic void flag_mismatch(string what, curve_point_t exp_pt, curve_point_t act_pt);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("checker: %s at %0t: expected x=%0d y=%0d idx=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
               what, $time, exp_pt.x, exp_pt.y, exp_pt.index, exp_pt.last,
               act_pt.x, act_pt.y, act_pt.index, act_pt.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      active_mode    = MODE_BEZIER;
      mismatch_count = 0;
      points_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.x     = out_point_x;
        got.y     = out_point_y;
        got.index = out_sample_index;
        got.last  = out_last_point;
        if (expected_points.size() == 0) begin
          flag_mismatch("point with no segment pending", '0, got);
        end else begin
          want = expected_points.pop_front();
          points_checked++;
          if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
              got.last !== want.last) begin
            flag_mismatch("point mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_curve_points(active_mode, {in_p0_x, in_p1_x, in_p2_x, in_p3_x},
                           {in_p0_y, in_p1_y, in_p2_y, in_p3_y});
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == MODE_ADDR) begin
        active_mode = curve_mode_t'(cfg_pwdata[0]);
      end
    end
    points_pending = expected_points.size();
  end

endmodule

[test/tb_cubic_curve_point_generator_unit.sv]
// testbench top: drives segments, curve_mode writes and output stalls, then reports the verdict
`timescale 1ns / 1ps

module tb_cubic_curve_point_generator_unit;
  import ccpg_pkg::*;

  localparam int ITEMS_PER_PHASE = 45;
  localparam int RANDOM_PHASES   = 6;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic SPARE_INDEX   = 1'b1;
  localparam logic [CFG_ADDR_BITS-1:0] MODE_ADDR  = {REG_CURVE_MODE, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] SPARE_ADDR = {SPARE_INDEX, 2'b00};
  localparam coord_t COORD_MAX   = '1;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  coord_t                   in_p0_x, in_p0_y, in_p1_x, in_p1_y;
  coord_t                   in_p2_x, in_p2_y, in_p3_x, in_p3_y;
  logic                     out_valid;
  logic                     out_stall;
  coord_t                   out_point_x;
  coord_t                   out_point_y;
  sample_t                  out_sample_index;
  logic                     out_last_point;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;
  int unsigned              mismatch_count;
  int unsigned              points_pending;
  int unsigned              points_checked;

  logic        hold_req = 1'b0;
  bit          steady   = 1'b0;
  curve_mode_t sel_mode = MODE_BEZIER;
  int unsigned mode_segments [2];

  cubic_curve_point_generator_unit dut (.*);
  ccpg_point_checker checker_i (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic coord_t random_coord();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return COORD_MAX;
    if (r < 4) return coord_t'($urandom_range(0, 15));
    if (r < 6) return COORD_MAX - coord_t'($urandom_range(0, 15));
    return coord_t'($urandom());
  endfunction

  function automatic coord_quad_t quad(coord_t a, coord_t b, coord_t c, coord_t d);
    coord_quad_t q;
    q[0] = a;
    q[1] = b;
    q[2] = c;
    q[3] = d;
    return q;
  endfunction

  // output side stalls, plus one long hold on request
  initial begin
    int hold_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        hold_len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (addr == MODE_ADDR) sel_mode = curve_mode_t'(data[0]);
  endtask

  task automatic send_segment(input coord_quad_t xs, input coord_quad_t ys);
    int gap;
    gap = steady ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_p0_x  = xs[0];
    in_p0_y  = ys[0];
    in_p1_x  = xs[1];
    in_p1_y  = ys[1];
    in_p2_x  = xs[2];
    in_p2_y  = ys[2];
    in_p3_x  = xs[3];
    in_p3_y  = ys[3];
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mode_segments[sel_mode]++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic directed_segments();
    send_segment(quad(0, 0, 0, 0), quad(0, 0, 0, 0));
    send_segment(quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                 quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(quad(COORD_MAX, 0, 0, 0), quad(0, 0, 0, COORD_MAX));
    send_segment(quad(0, COORD_MAX, COORD_MAX, 0), quad(COORD_MAX, 0, 0, COORD_MAX));
    send_segment(quad(12'haaa, 12'h555, 12'haaa, 12'h555),
                 quad(12'h555, 12'haaa, 12'h555, 12'haaa));
    send_segment(quad(0, 1365, 2730, COORD_MAX), quad(COORD_MAX, 2730, 1365, 0));
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] cfg_word;
    coord_quad_t              xs;
    coord_quad_t              ys;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_p0_x     = '0;
    in_p0_y     = '0;
    in_p1_x     = '0;
    in_p1_y     = '0;
    in_p2_x     = '0;
    in_p2_y     = '0;
    in_p3_x     = '0;
    in_p3_y     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mode_segments[0] = 0;
    mode_segments[1] = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset value first, then both modes explicitly
    send_segment(quad(100, 2000, 3000, 4000), quad(4000, 3000, 2000, 100));
    drain();
    write_reg(MODE_ADDR, 32'(MODE_BEZIER));
    directed_segments();
    drain();
    write_reg(MODE_ADDR, 32'hffff_ffff);
    directed_segments();
    drain();
    // unused register index must leave the mode alone
    write_reg(SPARE_ADDR, 32'h0000_0000);
    send_segment(quad(7, 4000, 300, 2222), quad(1, 2, 4094, 4093));
    drain();
    // only bit 0 of the mode word counts
    write_reg(MODE_ADDR, 32'hffff_fffe);
    send_segment(quad(7, 4000, 300, 2222), quad(1, 2, 4094, 4093));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 2) == 0) write_reg(SPARE_ADDR, $urandom());
      cfg_word    = $urandom();
      cfg_word[0] = (ph % 2 == 0) ? MODE_BSPLINE : MODE_BEZIER;
      write_reg(MODE_ADDR, cfg_word);
      steady = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        for (int j = 0; j < 4; j++) begin
          xs[j] = random_coord();
          ys[j] = random_coord();
        end
        send_segment(xs, ys);
      end
      drain();
    end

    $display("tb: %0d segments sent (%0d bezier, %0d b-spline), %0d curve points checked",
             mode_segments[0] + mode_segments[1], mode_segments[0], mode_segments[1],
             points_checked);
    $display("tb: covered extreme and patterned coordinates, junk upper mode bits, %s",
             "an unused register write, a gapless stretch and a long output hold");
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
